@@ sv/elevation_color_ramp_flood_tint_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the elevation color ramp block
// Short forms of the concurrent checks used at the top level. All checks
// are clocked on aclk and are held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ELEVATION_COLOR_RAMP_FLOOD_TINT_MACROS_SVH
`define ELEVATION_COLOR_RAMP_FLOOD_TINT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ECR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ECR_ASSERT_IMPLY(lbl, pre, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (con)) \
        else $error(msg);

`endif

@@ sv/ecr_pkg.sv @@
// ----------------------------------------------------------------------------
// ecr_pkg
// Types, register codes and reset values shared by the color ramp modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

    // Field widths.
    localparam int ELEV_W     = 16;
    localparam int PT_ELEV_W  = 18;
    localparam int COLOR_W    = 8;
    localparam int PT_W       = 42;
    localparam int LEVELS_W   = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_POINTS = 6;
    localparam int NUM_W      = 26;
    localparam int DIV_STAGES = COLOR_W;

    // Channel order inside a color word.
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAMP_0       = 3'd0,
        REG_RAMP_1       = 3'd1,
        REG_RAMP_2       = 3'd2,
        REG_RAMP_3       = 3'd3,
        REG_RAMP_4       = 3'd4,
        REG_RAMP_5       = 3'd5,
        REG_FLOOD_LEVELS = 3'd6,
        REG_FLOOD_TINT   = 3'd7
    } cfg_reg_t;

    // Reset values of the registers.
    localparam logic [PT_W-1:0] RAMP_RESET [MAX_POINTS] = '{
        42'd800658292732, 42'd1904578396161, 42'd3968186450000,
        42'd3450779730220, 42'd2933386117520, 42'd2417326818080
    };
    localparam logic [LEVELS_W-1:0] FLOOD_LEVELS_RESET = 48'd429500006410;
    localparam logic [COLOR_W-1:0]  FLOOD_TINT_RESET   = 8'd90;

    // Elevation used for samples outside the map.
    localparam logic signed [ELEV_W-1:0] OFF_MAP_ELEV = -16'sd10;

    // A tinted channel must stay below this value.
    localparam logic [COLOR_W:0] TINT_LIMIT = 9'd255;

    // One BGR color, blue in the lowest byte.
    typedef logic [2:0][COLOR_W-1:0] rgb_t;

    // Segment chosen for one sample, after the search stage.
    typedef struct packed {
        logic                        clamp;
        logic signed [PT_ELEV_W-1:0] q;
        logic signed [PT_ELEV_W-1:0] lo;
        logic signed [PT_ELEV_W-1:0] hi;
        rgb_t                        ca;
        rgb_t                        cb;
        rgb_t                        flood;
    } seg_t;

    // Interpolation numerators and the common divisor.
    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [PT_ELEV_W-1:0]  dvs;
        rgb_t                  flood;
    } num_t;

    // Partial state of the quotient pipeline.
    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        rgb_t                  quot;
        logic [PT_ELEV_W-1:0]  dvs;
        rgb_t                  flood;
    } div_t;

    // Finished result, heat color in the low half.
    typedef struct packed {
        rgb_t flood;
        rgb_t heat;
    } res_t;

    // Signed elevation of a ramp point.
    function automatic logic signed [PT_ELEV_W-1:0] pt_elev(input logic [PT_W-1:0] pt);
        return signed'(pt[PT_ELEV_W-1:0]);
    endfunction

    // Color of a ramp point.
    function automatic rgb_t pt_rgb(input logic [PT_W-1:0] pt);
        return rgb_t'(pt[PT_W-1:PT_ELEV_W]);
    endfunction

endpackage

`default_nettype wire

@@ sv/ecr_cfg.sv @@
// ----------------------------------------------------------------------------
// ecr_cfg
// Configuration registers: ramp points, flood levels and flood tint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_cfg #(
    parameter int RAMP_POINTS = 6
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [ecr_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  wire logic [ecr_pkg::CFG_DATA_W-1:0]              cfg_data,
    output logic      [RAMP_POINTS-1:0][ecr_pkg::PT_W-1:0]   ramp_pts,
    output logic      [ecr_pkg::LEVELS_W-1:0]                flood_levels,
    output logic      [ecr_pkg::COLOR_W-1:0]                 flood_tint
);

    logic [RAMP_POINTS-1:0][ecr_pkg::PT_W-1:0] ramp_reg;
    logic [ecr_pkg::LEVELS_W-1:0]              levels_reg;
    logic [ecr_pkg::COLOR_W-1:0]               tint_reg;

    // Ramp points; indexes of points beyond the ramp length are dropped.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < RAMP_POINTS; i++) begin
            if (!aresetn) begin
                ramp_reg[i] <= ecr_pkg::RAMP_RESET[i];
            end else if (cfg_wr_en && (cfg_index == ecr_pkg::CFG_IDX_W'(ecr_pkg::REG_RAMP_0)
                                                 + ecr_pkg::CFG_IDX_W'(i))) begin
                ramp_reg[i] <= cfg_data[ecr_pkg::PT_W-1:0];
            end
        end
    end

    // Flood levels and tint.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= ecr_pkg::FLOOD_LEVELS_RESET;
            tint_reg   <= ecr_pkg::FLOOD_TINT_RESET;
        end else if (cfg_wr_en) begin
            unique case (ecr_pkg::cfg_reg_t'(cfg_index))
                ecr_pkg::REG_FLOOD_LEVELS: levels_reg <= cfg_data[ecr_pkg::LEVELS_W-1:0];
                ecr_pkg::REG_FLOOD_TINT:   tint_reg   <= cfg_data[ecr_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign ramp_pts     = ramp_reg;
    assign flood_levels = levels_reg;
    assign flood_tint   = tint_reg;

endmodule

`default_nettype wire

@@ sv/ecr_front.sv @@
// ----------------------------------------------------------------------------
// ecr_front
// Input stage and segment search: picks the bracketing ramp points or the
// clamp color, and applies the flood tint to the source pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_front #(
    parameter int RAMP_POINTS = 6
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [ecr_pkg::ELEV_W-1:0]         in_elev,
    input  wire logic                                      in_off_map,
    input  wire ecr_pkg::rgb_t                             in_src,
    input  wire logic [RAMP_POINTS-1:0][ecr_pkg::PT_W-1:0] ramp_pts,
    input  wire logic [ecr_pkg::LEVELS_W-1:0]              flood_levels,
    input  wire logic [ecr_pkg::COLOR_W-1:0]               flood_tint,
    output logic                                           seg_valid,
    input  wire logic                                      seg_ready,
    output ecr_pkg::seg_t                                  seg
);

    localparam int LAST = RAMP_POINTS - 1;

    logic                                a_valid_reg;
    logic signed [ecr_pkg::ELEV_W-1:0]   a_elev_reg;
    ecr_pkg::rgb_t                       a_src_reg;
    logic                                a_ready;
    logic                                b_valid_reg;
    ecr_pkg::seg_t                       seg_reg;
    ecr_pkg::seg_t                       seg_next;
    logic                                b_ready;

    logic signed [ecr_pkg::PT_ELEV_W-1:0] q;
    logic signed [ecr_pkg::ELEV_W-1:0]    lvl [3];
    logic [2:0][ecr_pkg::COLOR_W:0]       tint_sum;
    logic [2:0]                           tint_hit;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || seg_ready;
    assign in_ready = a_ready;

    // Stage A: register the sample, substituting the off-map elevation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_elev_reg <= in_off_map ? ecr_pkg::OFF_MAP_ELEV : in_elev;
            a_src_reg  <= in_src;
        end
    end

    // Stage B: ramp segment search and flood tint.
    always_comb begin
        q = {a_elev_reg, 2'b00};

        seg_next.q     = q;
        seg_next.clamp = 1'b0;
        seg_next.lo    = ecr_pkg::pt_elev(ramp_pts[LAST-1]);
        seg_next.hi    = ecr_pkg::pt_elev(ramp_pts[LAST]);
        seg_next.ca    = ecr_pkg::pt_rgb(ramp_pts[LAST-1]);
        seg_next.cb    = ecr_pkg::pt_rgb(ramp_pts[LAST]);

        // Descending scan so the lowest point above the sample wins.
        for (int i = LAST - 1; i >= 1; i--) begin
            if (q < ecr_pkg::pt_elev(ramp_pts[i])) begin
                seg_next.lo = ecr_pkg::pt_elev(ramp_pts[i-1]);
                seg_next.hi = ecr_pkg::pt_elev(ramp_pts[i]);
                seg_next.ca = ecr_pkg::pt_rgb(ramp_pts[i-1]);
                seg_next.cb = ecr_pkg::pt_rgb(ramp_pts[i]);
            end
        end

        // Outside the ramp the end color passes through unchanged.
        if (q < ecr_pkg::pt_elev(ramp_pts[0])) begin
            seg_next.clamp = 1'b1;
            seg_next.ca    = ecr_pkg::pt_rgb(ramp_pts[0]);
        end else if (q >= ecr_pkg::pt_elev(ramp_pts[LAST])) begin
            seg_next.clamp = 1'b1;
            seg_next.ca    = ecr_pkg::pt_rgb(ramp_pts[LAST]);
        end

        // Flood: the first level the sample lies below picks the channel.
        for (int k = 0; k < 3; k++) begin
            lvl[k]      = signed'(flood_levels[k*ecr_pkg::ELEV_W +: ecr_pkg::ELEV_W]);
            tint_sum[k] = {1'b0, a_src_reg[k]} + {1'b0, flood_tint};
        end
        tint_hit = 3'b000;
        if (a_elev_reg < lvl[ecr_pkg::CH_BLUE]) begin
            tint_hit[ecr_pkg::CH_BLUE] = 1'b1;
        end else if (a_elev_reg < lvl[ecr_pkg::CH_GREEN]) begin
            tint_hit[ecr_pkg::CH_GREEN] = 1'b1;
        end else if (a_elev_reg < lvl[ecr_pkg::CH_RED]) begin
            tint_hit[ecr_pkg::CH_RED] = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            if (tint_hit[k] && (tint_sum[k] < ecr_pkg::TINT_LIMIT)) begin
                seg_next.flood[k] = tint_sum[k][ecr_pkg::COLOR_W-1:0];
            end else begin
                seg_next.flood[k] = a_src_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            seg_reg <= seg_next;
        end
    end

    assign seg_valid = b_valid_reg;
    assign seg       = seg_reg;

endmodule

`default_nettype wire

@@ sv/ecr_interp.sv @@
// ----------------------------------------------------------------------------
// ecr_interp
// Interpolation weights, per-channel products and the summed numerators.
// Three register stages: differences, multiply, add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_interp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          seg_valid,
    output logic               seg_ready,
    input  wire ecr_pkg::seg_t seg,
    output logic               num_valid,
    input  wire logic          num_ready,
    output ecr_pkg::num_t      num
);

    localparam int W  = ecr_pkg::PT_ELEV_W;
    localparam int NW = ecr_pkg::NUM_W;

    // Stage C registers: weights and divisor.
    logic                 c_valid_reg;
    logic [W-1:0]         c_wa_reg, c_wb_reg, c_dvs_reg;
    logic [W-1:0]         c_wa_next, c_wb_next, c_dvs_next;
    ecr_pkg::rgb_t        c_ca_reg, c_cb_reg, c_flood_reg;
    logic                 c_ready;

    // Stage D registers: products.
    logic                 d_valid_reg;
    logic [2:0][NW-1:0]   d_pa_reg, d_pb_reg;
    logic [2:0][NW-1:0]   d_pa_next, d_pb_next;
    logic [W-1:0]         d_dvs_reg;
    ecr_pkg::rgb_t        d_flood_reg;
    logic                 d_ready;

    // Stage E registers: numerators.
    logic                 e_valid_reg;
    ecr_pkg::num_t        num_reg;
    ecr_pkg::num_t        num_next;
    logic                 e_ready;

    logic signed [W:0]    diff_hq, diff_ql, diff_hl;

    assign c_ready   = !c_valid_reg || d_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign e_ready   = !e_valid_reg || num_ready;
    assign seg_ready = c_ready;

    // Stage C: distances to both points. A clamped sample becomes a unit
    // segment that returns its color unchanged.
    always_comb begin
        diff_hq = {seg.hi[W-1], seg.hi} - {seg.q[W-1], seg.q};
        diff_ql = {seg.q[W-1], seg.q} - {seg.lo[W-1], seg.lo};
        diff_hl = {seg.hi[W-1], seg.hi} - {seg.lo[W-1], seg.lo};
        if (seg.clamp) begin
            c_wa_next  = W'(1);
            c_wb_next  = '0;
            c_dvs_next = W'(1);
        end else begin
            c_wa_next  = diff_hq[W-1:0];
            c_wb_next  = diff_ql[W-1:0];
            c_dvs_next = diff_hl[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && seg_valid) begin
            c_wa_reg    <= c_wa_next;
            c_wb_reg    <= c_wb_next;
            c_dvs_reg   <= c_dvs_next;
            c_ca_reg    <= seg.ca;
            c_cb_reg    <= seg.cb;
            c_flood_reg <= seg.flood;
        end
    end

    // Stage D: weight times color for each channel and each end point.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d_pa_next[c] = {{(NW-W){1'b0}}, c_wa_reg}
                         * {{(NW-ecr_pkg::COLOR_W){1'b0}}, c_ca_reg[c]};
            d_pb_next[c] = {{(NW-W){1'b0}}, c_wb_reg}
                         * {{(NW-ecr_pkg::COLOR_W){1'b0}}, c_cb_reg[c]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && c_valid_reg) begin
            d_pa_reg    <= d_pa_next;
            d_pb_reg    <= d_pb_next;
            d_dvs_reg   <= c_dvs_reg;
            d_flood_reg <= c_flood_reg;
        end
    end

    // Stage E: numerator sum; it never exceeds 255 times the divisor.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num_next.num[c] = d_pa_reg[c] + d_pb_reg[c];
        end
        num_next.dvs   = d_dvs_reg;
        num_next.flood = d_flood_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && d_valid_reg) begin
            num_reg <= num_next;
        end
    end

    assign num_valid = e_valid_reg;
    assign num       = num_reg;

endmodule

`default_nettype wire

@@ sv/ecr_div.sv @@
// ----------------------------------------------------------------------------
// ecr_div
// Pipelined restoring division of the three numerators by the segment
// length, one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          num_valid,
    output logic               num_ready,
    input  wire ecr_pkg::num_t num,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ecr_pkg::res_t      res
);

    localparam int NS = ecr_pkg::DIV_STAGES;
    localparam int NW = ecr_pkg::NUM_W;
    localparam int W  = ecr_pkg::PT_ELEV_W;
    localparam int CW = ecr_pkg::COLOR_W;

    logic          v_reg  [NS];
    ecr_pkg::div_t st_reg [NS];
    logic [NS:0]   rdy;
    ecr_pkg::div_t st_init;

    assign rdy[NS]   = res_ready;
    assign num_ready = rdy[0];

    // Division starts with the whole numerator as remainder.
    always_comb begin
        st_init.rem   = num.num;
        st_init.quot  = '0;
        st_init.dvs   = num.dvs;
        st_init.flood = num.flood;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int SH = NS - 1 - s;

        ecr_pkg::div_t st_in;
        ecr_pkg::div_t st_next;
        logic          v_in;
        logic [NW-1:0] sub;

        if (s == 0) begin : g_first
            assign st_in = st_init;
            assign v_in  = num_valid;
        end else begin : g_rest
            assign st_in = st_reg[s-1];
            assign v_in  = v_reg[s-1];
        end

        assign rdy[s] = !v_reg[s] || rdy[s+1];

        // Trial subtraction of the shifted divisor for each channel.
        always_comb begin
            sub             = {{(NW-W){1'b0}}, st_in.dvs} << SH;
            st_next.dvs     = st_in.dvs;
            st_next.flood   = st_in.flood;
            for (int c = 0; c < 3; c++) begin
                if (st_in.rem[c] >= sub) begin
                    st_next.rem[c]  = st_in.rem[c] - sub;
                    st_next.quot[c] = {st_in.quot[c][CW-2:0], 1'b1};
                end else begin
                    st_next.rem[c]  = st_in.rem[c];
                    st_next.quot[c] = {st_in.quot[c][CW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[s] && v_in) begin
                st_reg[s] <= st_next;
            end
        end
    end

    assign res_valid = v_reg[NS-1];
    assign res.heat  = st_reg[NS-1].quot;
    assign res.flood = st_reg[NS-1].flood;

endmodule

`default_nettype wire

@@ sv/elevation_color_ramp_flood_tint.sv @@
// ----------------------------------------------------------------------------
// elevation_color_ramp_flood_tint
// Per-pixel heat color from a piecewise linear elevation ramp, and the source
// pixel tinted according to flood levels.
//
//   Channel   Ports                      Contents
//   input     s_axis_t*                  elevation, off-map flag, source BGR
//   result    m_axis_t*                  heat BGR, tinted BGR
//   config    cfg_wr_en/index/data       ramp points, flood levels, tint
//
// One pixel enters per clock unless the output stalls; there are two search
// stages, three interpolation, eight quotient and the output register.
// The quotient pipeline sets the depth, one bit of each channel per stage.
// Reset clears every valid bit and restores the register reset values.
// Each stage has its own valid bit and moves whenever the next stage is
// free, so a stalled result holds only the stages behind it that are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "elevation_color_ramp_flood_tint_macros.svh"

module elevation_color_ramp_flood_tint #(
    parameter int RAMP_POINTS = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input transactions.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // elevation[15:0], src_blue[23:16], src_green[31:24], src_red[39:32]
    input  wire logic [39:0]                       s_axis_tdata,
    // off_map[0]
    input  wire logic                              s_axis_tuser,
    // Result transactions.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // heat_blue[7:0], heat_green[15:8], heat_red[23:16],
    // flood_blue[31:24], flood_green[39:32], flood_red[47:40]
    output logic [47:0]                            m_axis_tdata,
    // Register writes.
    input  wire logic                              cfg_wr_en,
    input  wire logic [ecr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ecr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [RAMP_POINTS-1:0][ecr_pkg::PT_W-1:0] ramp_pts;
    logic [ecr_pkg::LEVELS_W-1:0]              flood_levels;
    logic [ecr_pkg::COLOR_W-1:0]               flood_tint;

    logic          seg_valid, seg_ready;
    ecr_pkg::seg_t seg;
    logic          num_valid, num_ready;
    ecr_pkg::num_t num;
    logic          res_valid, res_ready;
    ecr_pkg::res_t res;

    logic          out_valid_reg;
    ecr_pkg::res_t out_reg;

    // Register file.
    ecr_cfg #(
        .RAMP_POINTS (RAMP_POINTS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ramp_pts     (ramp_pts),
        .flood_levels (flood_levels),
        .flood_tint   (flood_tint)
    );

    // Segment search and flood tint.
    ecr_front #(
        .RAMP_POINTS (RAMP_POINTS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_elev      (signed'(s_axis_tdata[15:0])),
        .in_off_map   (s_axis_tuser),
        .in_src       (ecr_pkg::rgb_t'(s_axis_tdata[39:16])),
        .ramp_pts     (ramp_pts),
        .flood_levels (flood_levels),
        .flood_tint   (flood_tint),
        .seg_valid    (seg_valid),
        .seg_ready    (seg_ready),
        .seg          (seg)
    );

    // Weights, products and numerators.
    ecr_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num)
    );

    // Quotient pipeline.
    ecr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // An empty output register frees every stage, so input must be taken.
    `ECR_ASSERT_IMPLY(a_accept_when_drained, !m_axis_tvalid, s_axis_tready,
        "input not ready while the output register is empty")

    // An interpolated segment always brackets the sample.
    `ECR_ASSERT_IMPLY(a_segment_brackets, seg_valid && !seg.clamp,
        (seg.q >= seg.lo) && (seg.q < seg.hi),
        "selected segment does not bracket the sample")

    // The divisor entering the quotient pipeline is never zero.
    `ECR_ASSERT_IMPLY(a_divisor_nonzero, num_valid, num.dvs != '0,
        "zero divisor entering the quotient pipeline")

endmodule

`default_nettype wire
